@@ hw/rtl/bfa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the bitmap fragment allocator.
// No dependencies.
package bfa_pkg;

   localparam int ADDR_W   = 48;
   localparam int STRIDE_W = 18;
   localparam int COUNT_W  = 11;
   localparam int REQ_W    = 7;
   localparam int WORD_W   = 64;
   localparam int BOFF_W   = 6;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      STATUS_GRANTED  = 2'd0,
      STATUS_NONE     = 2'd1,
      STATUS_RELEASED = 2'd2,
      STATUS_RANGE    = 2'd3
   } status_type;

   typedef enum logic {
      MODE_ALLOC   = 1'b0,
      MODE_RELEASE = 1'b1
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE   = 2'd0,
      CSR_STRIDE = 2'd1,
      CSR_COUNT  = 2'd2,
      CSR_SPARE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ hw/rtl/bfa_map.sv @@
`timescale 1ns / 1ps
// Usage bitmap storage: one word written and one word read per cycle.
// Depends on bfa_pkg.
module bfa_map #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [bfa_pkg::WORD_W-1:0] wr_data,
   input  logic [AW-1:0]          rd_addr,
   output logic [bfa_pkg::WORD_W-1:0] rd_data
);
   import bfa_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/bfa_divider.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring divider: address offset by fragment stride.
// Depends on bfa_pkg.
module bfa_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bfa_pkg::ADDR_W-1:0]   dividend,
   input  logic [bfa_pkg::STRIDE_W-1:0] divisor,
   output bfa_pkg::div_status_type      status,
   output logic [bfa_pkg::ADDR_W-1:0]   quotient
);
   import bfa_pkg::*;

   localparam int CNT_W = $clog2(ADDR_W + 1);

   logic [ADDR_W-1:0]   num_ff, num_in;
   logic [ADDR_W-1:0]   quo_ff, quo_in;
   logic [STRIDE_W-1:0] rem_ff, rem_in;
   logic [STRIDE_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STRIDE_W:0]   trial;
   logic [STRIDE_W:0]   diff;

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[ADDR_W-1]};
      diff    = trial - {1'b0, div_ff};
      if (start) begin
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[ADDR_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[STRIDE_W-1:0];
            quo_in = {quo_ff[ADDR_W-2:0], 1'b1};
         end else begin
            rem_in = trial[STRIDE_W-1:0];
            quo_in = {quo_ff[ADDR_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ADDR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
endmodule

@@ hw/rtl/bitmap_fragment_allocator_unit.sv @@
`timescale 1ns / 1ps
// Next-fit bitmap fragment allocator: sequencer, grant list and output word.
// Depends on bfa_pkg, bfa_map and bfa_divider.
//
//  channel | ports                              | content
//  req     | req_tvalid/tready/tdata/tuser      | tdata: request_count, release_address; tuser: mode
//  rsp     | rsp_tvalid/tready/tdata/tlast      | tdata: fragment_index, fragment_address, status, segment_full
//  csr     | csr_we/csr_index/csr_wdata         | segment_base, fragment_stride, fragment_count
//
// Allocate: each bitmap word touched is read, loaded, scanned bit by bit from the pointer
// until a stop, and written back; then each result word goes through list read, multiply,
// load and hand over.
// Release: the serial divider, then the map update (read, load, clear) and the result.
// After reset a clearing pass over the MAX_FRAGMENTS/64 (rounded up) bitmap words holds req_tready low.
// A stalled result word holds the sequencer; one item is worked on at a time.
module bitmap_fragment_allocator_unit #(
   parameter int MAX_FRAGMENTS = 1024,
   parameter int MAX_REQUEST   = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // request_count[6:0], release_address[54:7]
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [((($clog2(MAX_FRAGMENTS) + 51) + 7) / 8) * 8 - 1:0] rsp_tdata,
                                    // fragment_index, fragment_address, status, segment_full
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [bfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bfa_pkg::ADDR_W-1:0]    csr_wdata
);
   import bfa_pkg::*;

   localparam int IW        = $clog2(MAX_FRAGMENTS);
   localparam int RDW       = (((IW + 51) + 7) / 8) * 8;
   localparam int CW        = $clog2(MAX_FRAGMENTS + 1);
   localparam int MAP_WORDS = (MAX_FRAGMENTS + WORD_W - 1) / WORD_W;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int RQW       = $clog2(MAX_REQUEST + 1);
   localparam int LA        = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;
   localparam int PW        = IW + STRIDE_W;

   typedef enum logic [11:0] {
      ST_CLEAR = 12'b000000000001,
      ST_IDLE  = 12'b000000000010,
      ST_DIV   = 12'b000000000100,
      ST_RD    = 12'b000000001000,
      ST_LOAD  = 12'b000000010000,
      ST_SCAN  = 12'b000000100000,
      ST_WB    = 12'b000001000000,
      ST_RCLR  = 12'b000010000000,
      ST_EM_RD = 12'b000100000000,
      ST_MUL   = 12'b001000000000,
      ST_OUT   = 12'b010000000000,
      ST_WAIT  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]   base_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [CW-1:0]       n_eff;

   logic [CW-1:0]       ss_ff, ss_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [RQW-1:0]      want_ff, want_in;
   logic [RQW-1:0]      gcnt_ff, gcnt_in;
   logic [RQW-1:0]      emit_ff, emit_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [AW-1:0]       waddr_ff, waddr_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic                mode_ff, mode_in;
   logic                stop_ff, stop_in;
   logic                nil_ff, nil_in;
   logic [1:0]          nil_st_ff, nil_st_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [IW-1:0]       eidx_ff, eidx_in;

   logic [IW-1:0]       list_mem [MAX_REQUEST];
   logic [IW-1:0]       list_q_ff;
   logic                list_we;

   logic                rv_ff, rv_in;
   logic                rl_ff, rl_in;
   logic [IW-1:0]       ridx_ff, ridx_in;
   logic [ADDR_W-1:0]   raddr_ff, raddr_in;
   logic [1:0]          rst_ff, rst_in;
   logic                rfull_ff, rfull_in;

   logic                map_we;
   logic [AW-1:0]       map_waddr;
   logic [WORD_W-1:0]   map_wdata;
   logic [AW-1:0]       map_raddr;
   logic [WORD_W-1:0]   map_rdata;

   logic                div_start;
   div_status_type      div_status;
   logic [ADDR_W-1:0]   div_q;

   logic [31:0]         posx;
   logic [BOFF_W-1:0]   boff;
   logic [31:0]         reqx;
   logic [IW-1:0]       mul_src;

   bfa_map #(.DEPTH(MAP_WORDS), .AW(AW)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   bfa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata[54:7] - base_ff),
      .divisor  (stride_ff),
      .status   (div_status),
      .quotient (div_q)
   );

   assign n_eff = (32'(count_ff) < MAX_FRAGMENTS) ? CW'(count_ff) : CW'(MAX_FRAGMENTS);
   assign posx  = 32'(pos_ff);
   assign boff  = posx[BOFF_W-1:0];
   assign reqx  = 32'(req_tdata[6:0]);
   assign mul_src = mode_ff ? pos_ff[IW-1:0] : list_q_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign div_start  = req_tvalid && req_tready && (req_tuser == MODE_RELEASE);
   assign list_we    = (state_ff == ST_SCAN) && !(want_ff == '0 || pos_ff >= n_eff)
                       && !word_ff[boff];

   always_comb begin
      map_we    = 1'b0;
      map_waddr = waddr_ff;
      map_wdata = word_ff;
      case (state_ff)
         ST_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = '0;
         end
         ST_WB: begin
            map_we = 1'b1;
         end
         ST_RCLR: begin
            map_we = 1'b1;
            map_wdata[boff] = 1'b0;
         end
         default: begin
            map_we = 1'b0;
         end
      endcase
   end

   assign map_raddr = waddr_ff;

   always_comb begin
      state_in   = state_ff;
      ss_in      = ss_ff;
      pos_in     = pos_ff;
      want_in    = want_ff;
      gcnt_in    = gcnt_ff;
      emit_in    = emit_ff;
      clr_in     = clr_ff;
      waddr_in   = waddr_ff;
      word_in    = word_ff;
      mode_in    = mode_ff;
      stop_in    = stop_ff;
      nil_in     = nil_ff;
      nil_st_in  = nil_st_ff;
      prod_in    = prod_ff;
      eidx_in    = eidx_ff;
      rv_in      = rv_ff;
      rl_in      = rl_ff;
      ridx_in    = ridx_ff;
      raddr_in   = raddr_ff;
      rst_in     = rst_ff;
      rfull_in   = rfull_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == MAP_WORDS - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tuser;
               gcnt_in = '0;
               emit_in = '0;
               nil_in  = 1'b0;
               want_in = (reqx > MAX_REQUEST) ? RQW'(MAX_REQUEST) : RQW'(reqx);
               if (req_tuser == MODE_RELEASE) begin
                  state_in = ST_DIV;
               end else if (req_tdata[6:0] == '0 || ss_ff >= n_eff) begin
                  nil_in    = 1'b1;
                  nil_st_in = STATUS_NONE;
                  state_in  = ST_OUT;
               end else begin
                  pos_in   = ss_ff;
                  waddr_in = AW'(32'(ss_ff) >> BOFF_W);
                  state_in = ST_RD;
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               if (div_q >= ADDR_W'(n_eff)) begin
                  nil_in    = 1'b1;
                  nil_st_in = STATUS_RANGE;
                  state_in  = ST_OUT;
               end else begin
                  pos_in   = div_q[CW-1:0];
                  waddr_in = AW'(div_q >> BOFF_W);
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            word_in  = map_rdata;
            state_in = mode_ff ? ST_RCLR : ST_SCAN;
         end
         ST_SCAN: begin
            if (want_ff == '0 || pos_ff >= n_eff) begin
               ss_in    = pos_ff;
               stop_in  = 1'b1;
               state_in = ST_WB;
            end else begin
               if (!word_ff[boff]) begin
                  word_in[boff] = 1'b1;
                  gcnt_in = gcnt_ff + 1'b1;
                  want_in = want_ff - 1'b1;
               end
               pos_in = pos_ff + 1'b1;
               if (boff == '1) begin
                  stop_in  = 1'b0;
                  state_in = ST_WB;
               end
            end
         end
         ST_WB: begin
            if (stop_ff) begin
               if (gcnt_ff == '0) begin
                  nil_in    = 1'b1;
                  nil_st_in = STATUS_NONE;
                  state_in  = ST_OUT;
               end else begin
                  state_in = ST_EM_RD;
               end
            end else begin
               waddr_in = AW'(32'(pos_ff) >> BOFF_W);
               state_in = ST_RD;
            end
         end
         ST_RCLR: begin
            if (pos_ff < ss_ff) begin
               ss_in = pos_ff;
            end
            state_in = ST_MUL;
         end
         ST_EM_RD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = mul_src * stride_ff;
            eidx_in  = mul_src;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rv_in    = 1'b1;
            rfull_in = (ss_ff >= n_eff);
            if (nil_ff) begin
               ridx_in  = '0;
               raddr_in = '0;
               rst_in   = nil_st_ff;
               rl_in    = 1'b1;
            end else begin
               ridx_in  = eidx_ff;
               raddr_in = base_ff + ADDR_W'(prod_ff);
               rst_in   = mode_ff ? STATUS_RELEASED : STATUS_GRANTED;
               rl_in    = mode_ff || (emit_ff == gcnt_ff - 1'b1);
            end
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (rsp_tready) begin
               rv_in = 1'b0;
               if (rl_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_in  = emit_ff + 1'b1;
                  state_in = ST_EM_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[gcnt_ff[LA-1:0]] <= pos_ff[IW-1:0];
      end
      list_q_ff <= list_mem[emit_ff[LA-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         ss_ff     <= '0;
         rv_ff     <= 1'b0;
         base_ff   <= '0;
         stride_ff <= STRIDE_W'(12);
         count_ff  <= COUNT_W'(1024);
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ss_ff    <= ss_in;
         rv_ff    <= rv_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BASE:   base_ff   <= csr_wdata;
               CSR_STRIDE: stride_ff <= csr_wdata[STRIDE_W-1:0];
               CSR_COUNT:  count_ff  <= csr_wdata[COUNT_W-1:0];
               default:    count_ff  <= count_ff;
            endcase
         end
      end
      pos_ff     <= pos_in;
      want_ff    <= want_in;
      gcnt_ff    <= gcnt_in;
      emit_ff    <= emit_in;
      waddr_ff   <= waddr_in;
      word_ff    <= word_in;
      mode_ff    <= mode_in;
      stop_ff    <= stop_in;
      nil_ff     <= nil_in;
      nil_st_ff  <= nil_st_in;
      prod_ff    <= prod_in;
      eidx_ff    <= eidx_in;
      rl_ff      <= rl_in;
      ridx_ff    <= ridx_in;
      raddr_ff   <= raddr_in;
      rst_ff     <= rst_in;
      rfull_ff   <= rfull_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tlast  = rl_ff;
   assign rsp_tdata  = RDW'({rfull_ff, rst_ff, raddr_ff, ridx_ff});
endmodule

@@ dv/bitmap_fragment_allocator_unit_chk.sv @@
`timescale 1ns / 1ps
// Checker for the bitmap fragment allocator: tracks the usage map and search pointer,
// predicts every response word and compares it field by field. Depends on bfa_pkg.
module bitmap_fragment_allocator_unit_chk
   import bfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [9:0]        index;
      logic [ADDR_W-1:0] address;
      status_type        status;
      logic              full;
      logic              last;
   } grant_word_type;

   grant_word_type    grant_q[$];
   logic              used_map[1024];
   logic [10:0]       search_ptr;
   logic [ADDR_W-1:0] seg_base;
   logic [17:0]       seg_stride;
   logic [10:0]       seg_count;

   assign pending_count = grant_q.size();

   function automatic logic [ADDR_W-1:0] frag_addr(int unsigned i);
      logic [ADDR_W+17:0] p;
      p = seg_base + i * seg_stride;
      return p[ADDR_W-1:0];
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic predict_word(logic mode, logic [6:0] want_in, logic [ADDR_W-1:0] raddr);
      grant_word_type w[$];
      grant_word_type g;
      int unsigned n, want, pos;
      logic [ADDR_W-1:0] off;
      logic [ADDR_W-1:0] quo;
      n = seg_count < 1024 ? seg_count : 1024;
      if (mode == MODE_ALLOC) begin
         want = want_in > 64 ? 64 : want_in;
         while (want > 0 && search_ptr < n) begin
            pos = search_ptr;
            while (pos < n && used_map[pos]) pos++;
            if (pos >= n) begin
               search_ptr = n;
               break;
            end
            while (want > 0 && pos < n && !used_map[pos]) begin
               used_map[pos] = 1'b1;
               g = '{pos[9:0], frag_addr(pos), STATUS_GRANTED, 1'b0, 1'b0};
               w.push_back(g);
               want--;
               pos++;
            end
            search_ptr = pos;
         end
         if (w.size() == 0) w.push_back('{10'd0, '0, STATUS_NONE, 1'b0, 1'b0});
      end else begin
         off = raddr - seg_base;
         if (seg_stride == 0 || (off / seg_stride) >= n) begin
            w.push_back('{10'd0, '0, STATUS_RANGE, 1'b0, 1'b0});
         end else begin
            quo = off / seg_stride;
            used_map[quo] = 1'b0;
            if (quo < search_ptr) search_ptr = quo;
            w.push_back('{quo[9:0], frag_addr(quo), STATUS_RELEASED, 1'b0, 1'b0});
         end
      end
      foreach (w[i]) begin
         w[i].full = search_ptr >= n;
         w[i].last = i == w.size() - 1;
         grant_q.push_back(w[i]);
      end
   endtask

   always @(posedge clock) begin
      grant_word_type e;
      if (reset) begin
         fail_count = 0;
         grant_q.delete();
         foreach (used_map[i]) used_map[i] = 1'b0;
         search_ptr = 0;
         seg_base = 0;
         seg_stride = 12;
         seg_count = 1024;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BASE:   seg_base = csr_wdata;
               CSR_STRIDE: seg_stride = csr_wdata[17:0];
               CSR_COUNT:  seg_count = csr_wdata[10:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_word(req_tuser, req_tdata[6:0], req_tdata[54:7]);
         if (rsp_tvalid && rsp_tready) begin
            if (grant_q.size() == 0) begin
               report("unexpected word", rsp_tdata, 0);
            end else begin
               e = grant_q.pop_front();
               if (rsp_tdata[9:0] != e.index) report("index", rsp_tdata[9:0], e.index);
               if (rsp_tdata[57:10] != e.address)
                  report("address", rsp_tdata[57:10], e.address);
               if (rsp_tdata[59:58] != e.status) report("status", rsp_tdata[59:58], e.status);
               if (rsp_tdata[60] != e.full) report("full", rsp_tdata[60], e.full);
               if (rsp_tlast != e.last) report("last", rsp_tlast, e.last);
            end
         end
      end
   end

endmodule

@@ dv/bitmap_fragment_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request and register stimulus, verdict.
// Depends on bfa_pkg, the allocator and bitmap_fragment_allocator_unit_chk.
module bitmap_fragment_allocator_unit_tb;
   import bfa_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;   // request_count[6:0], release_address[54:7]
   logic        req_tuser = 1'b0; // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // fragment_index, fragment_address, status, segment_full
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BASE;
   logic [ADDR_W-1:0]    csr_wdata = '0;

   int fail_count;
   int pending_count;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_off = 1'b0;
   int quiet_cycles = 0;
   logic [ADDR_W-1:0] cur_base = 0;
   logic [17:0]       cur_stride = 12;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bitmap_fragment_allocator_unit i_dut (.*);

   bitmap_fragment_allocator_unit_chk i_chk (.*);

   always @(negedge clock)
      rsp_tready <= !hold_off && ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("bitmap_fragment_allocator_unit_tb: errors");
         $finish;
      end
   end

   task automatic send_word(logic mode, logic [6:0] cnt, logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {1'b0, addr, cnt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain;
      while (pending_count != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [ADDR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (idx == CSR_BASE) cur_base = val;
      if (idx == CSR_STRIDE) cur_stride = val[17:0];
   endtask

   task automatic release_of(int unsigned idx);
      send_word(MODE_RELEASE, 7'($urandom),
                48'(cur_base + idx * cur_stride + $urandom_range(cur_stride - 1)));
   endtask

   task automatic random_phase(int items, int unsigned span);
      repeat (items) begin
         if ($urandom_range(99) < 55)
            send_word(MODE_ALLOC,
                      7'($urandom_range(99) < 85 ? $urandom_range(1, 16) : $urandom), '0);
         else if ($urandom_range(99) < 85 && cur_stride != 0)
            release_of($urandom_range(span));
         else
            send_word(MODE_RELEASE, 7'($urandom), 48'({$urandom, $urandom}));
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed
      send_word(MODE_ALLOC, 7'd1, '0);
      send_word(MODE_ALLOC, 7'd64, '0);
      send_word(MODE_ALLOC, 7'd127, '0);
      send_word(MODE_ALLOC, 7'd0, '0);
      release_of(3);
      release_of(3);
      release_of(1023);
      send_word(MODE_RELEASE, 7'h7f, 48'hFFFF_FFFF_FFFF);
      send_word(MODE_ALLOC, 7'd5, '0);
      drain();
      write_reg(CSR_COUNT, 48'd70);
      write_reg(CSR_BASE, 48'hFFFF_FFFF_F000);
      write_reg(CSR_STRIDE, 48'd131080);
      send_word(MODE_ALLOC, 7'd64, '0);
      send_word(MODE_ALLOC, 7'd64, '0);
      send_word(MODE_ALLOC, 7'd64, '0);
      release_of(69);
      send_word(MODE_RELEASE, 7'd0, 48'd100);
      send_word(MODE_ALLOC, 7'd64, '0);
      drain();
      write_reg(CSR_COUNT, 48'd0);
      send_word(MODE_ALLOC, 7'd3, '0);
      release_of(0);
      drain();
      write_reg(CSR_COUNT, 48'd2047);
      write_reg(CSR_STRIDE, 48'd0);
      send_word(MODE_RELEASE, 7'd0, 48'd5);
      drain();
      write_reg(CSR_STRIDE, 48'h3FFFF);
      write_reg(CSR_COUNT, 48'd1);
      send_word(MODE_ALLOC, 7'd2, '0);
      send_word(MODE_ALLOC, 7'd2, '0);
      drain();
      // random phases over several settings
      write_reg(CSR_BASE, 48'({$urandom, $urandom}));
      write_reg(CSR_STRIDE, 48'd1);
      write_reg(CSR_COUNT, 48'd96);
      random_phase(60, 110);
      drain();
      send_idle_pct = 51;
      write_reg(CSR_STRIDE, 48'($urandom_range(1, 131080)));
      write_reg(CSR_COUNT, 48'd40);
      random_phase(60, 45);
      drain();
      send_idle_pct = 0;
      stall_pct = 51;
      write_reg(CSR_BASE, 48'd0);
      write_reg(CSR_STRIDE, 48'd12);
      write_reg(CSR_COUNT, 48'd1024);
      random_phase(60, 1030);
      drain();
      send_idle_pct = 23;
      stall_pct = 23;
      write_reg(CSR_COUNT, 48'd200);
      random_phase(60, 210);
      drain();
      // long receiver hold-off while requests keep coming
      send_idle_pct = 0;
      stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (3000) @(negedge clock);
            hold_off = 1'b0;
         end
         random_phase(12, 210);
      join
      drain();
      if (fail_count == 0)
         $display("bitmap_fragment_allocator_unit_tb: clean");
      else
         $display("bitmap_fragment_allocator_unit_tb: errors");
      $finish;
   end

endmodule

@@ bitmap_fragment_allocator_unit.f @@
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_map.sv
hw/rtl/bfa_divider.sv
hw/rtl/bitmap_fragment_allocator_unit.sv
dv/bitmap_fragment_allocator_unit_chk.sv
dv/bitmap_fragment_allocator_unit_tb.sv
